// ===== hdl/pal_pkg.sv =====
// ---------------------------------------------------------------------------
// pal_pkg : shared types and constants of the positional array list
// Field widths, action codes and the control bundle broadcast to the cells.
// ---------------------------------------------------------------------------
package pal_pkg;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int CNT_W   = 7;
  localparam int ACT_W   = 2;
  // Width used for comparing a cell's own index against a position.
  localparam int IDX_W   = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // Broadcast to every cell in the cycle a transaction is accepted.
  typedef struct packed {
    logic              shift_up;    // successful insert
    logic              shift_down;  // successful delete
    logic              rd_en;       // successful get or delete
    logic [POS_W-1:0]  pos;         // position, clamped to the length on insert
    logic [WORD_W-1:0] word;        // word to insert
  } cell_ctrl_t;

endpackage

// ===== hdl/pal_cell.sv =====
// ---------------------------------------------------------------------------
// pal_cell : one storage cell of the list chain
// Holds one entry, takes its left or right neighbour on a shift, and drives
// its entry onto the read tree when its index is addressed.
// ---------------------------------------------------------------------------
module pal_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  pal_pkg::cell_ctrl_t         ctrl,
  input  logic [pal_pkg::WORD_W-1:0]  left_q,
  input  logic [pal_pkg::WORD_W-1:0]  right_q,
  output logic [pal_pkg::WORD_W-1:0]  q,
  output logic [pal_pkg::WORD_W-1:0]  rd_word
);

  localparam logic [pal_pkg::IDX_W-1:0] MY_IDX = pal_pkg::IDX_W'(IDX);

  logic [pal_pkg::IDX_W-1:0]  pos_ext;
  logic                       match;
  logic                       above;
  logic [pal_pkg::WORD_W-1:0] q_r;
  logic [pal_pkg::WORD_W-1:0] q_nxt;

  assign pos_ext = pal_pkg::IDX_W'(ctrl.pos);
  assign match   = (MY_IDX == pos_ext);
  assign above   = (MY_IDX >  pos_ext);

  always_comb begin
    q_nxt = q_r;
    if (ctrl.shift_up) begin
      if (above)      q_nxt = left_q;
      else if (match) q_nxt = ctrl.word;
    end else if (ctrl.shift_down) begin
      if (above || match) q_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q       = q_r;
  assign rd_word = (ctrl.rd_en && match) ? q_r : '0;

endmodule

// ===== hdl/positional_array_list.sv =====
// ---------------------------------------------------------------------------
// positional_array_list : ordered list of 32-bit words in a chain of cells
// Insert, get, delete and clear on a list bounded by a configured capacity.
// ---------------------------------------------------------------------------
//  channel | dir | ports                            | contents
//  --------+-----+----------------------------------+---------------------------
//  in_     | in  | in_tvalid/in_tready/in_tdata[48] | action, position, value
//  out_    | out | out_tvalid/out_tready/out_tdata  | ok, read_value, count
//  cfg_    | in  | cfg_we/cfg_wdata[7]              | capacity_in_use
//
//  One transaction is accepted per cycle unless a stall on out_tready backs up;
//  its result is registered in stage 1, where cells are OR-reduced into groups
//  of eight, and then in the output register, which ORs the group words.
//  rst_n (synchronous, active low) clears the length, pipeline valids and sets
//  the capacity to 64; entry contents are not reset.
//  A stall on out_tready holds the output register and backs up to in_tready.
// ---------------------------------------------------------------------------
module positional_array_list #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [1:0] action, [9:2] position, [41:10] value, [47:42] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // out_tdata: [0] ok, [32:1] read_value, [39:33] count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int GRP    = 8;
  localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
  localparam int DCAP   = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [pal_pkg::CNT_W-1:0] DEPTH_CAP = pal_pkg::CNT_W'(DCAP);

  // --- input decode
  pal_pkg::action_t              act;
  logic [pal_pkg::POS_W-1:0]     pos;
  logic [pal_pkg::WORD_W-1:0]    word;
  logic                          in_acc;

  assign act    = pal_pkg::action_t'(in_tdata[1:0]);
  assign pos    = in_tdata[9:2];
  assign word   = in_tdata[41:10];
  assign in_acc = in_tvalid && in_tready;

  // --- capacity and length
  logic [pal_pkg::CNT_W-1:0] cap_r;
  logic [pal_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pal_pkg::CNT_W-1:0] eff_cap;
  logic [pal_pkg::POS_W-1:0] cnt_ext;
  logic                      ins_ok, rd_ok, op_ok;

  always_ff @(posedge clk) begin
    if (!rst_n)      cap_r <= pal_pkg::CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  assign eff_cap = (cap_r < DEPTH_CAP) ? cap_r : DEPTH_CAP;
  assign cnt_ext = pal_pkg::POS_W'(cnt_r);
  assign ins_ok  = (cnt_r < eff_cap);
  assign rd_ok   = (pos < cnt_ext);

  pal_pkg::cell_ctrl_t ctrl;

  always_comb begin
    ctrl       = '0;
    ctrl.word  = word;
    ctrl.pos   = pos;
    cnt_nxt    = cnt_r;
    op_ok      = 1'b0;
    unique case (act)
      pal_pkg::ACT_INSERT: begin
        op_ok    = ins_ok;
        ctrl.pos = (pos > cnt_ext) ? cnt_ext : pos;   // past the end: append
        if (in_acc && ins_ok) begin
          ctrl.shift_up = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      pal_pkg::ACT_GET: begin
        op_ok      = rd_ok;
        ctrl.rd_en = in_acc && rd_ok;
      end
      pal_pkg::ACT_DELETE: begin
        op_ok      = rd_ok;
        ctrl.rd_en = in_acc && rd_ok;
        if (in_acc && rd_ok) begin
          ctrl.shift_down = 1'b1;
          cnt_nxt         = cnt_r - 1'b1;
        end
      end
      pal_pkg::ACT_CLEAR: begin
        op_ok = 1'b1;
        if (in_acc) cnt_nxt = '0;
      end
      default: op_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // --- cell chain: neighbours hand entries up on insert, down on delete
  logic [pal_pkg::WORD_W-1:0] cell_q  [DEPTH];
  logic [pal_pkg::WORD_W-1:0] cell_rd [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [pal_pkg::WORD_W-1:0] lq, rq;
    if (i == 0) begin : g_first
      assign lq = cell_q[i];
    end else begin : g_mid_l
      assign lq = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rq = cell_q[i];
    end else begin : g_mid_r
      assign rq = cell_q[i+1];
    end
    pal_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (lq),
      .right_q (rq),
      .q       (cell_q[i]),
      .rd_word (cell_rd[i])
    );
  end

  // --- read tree, first level: groups of eight into registers
  logic [pal_pkg::WORD_W-1:0] grp_in [NGRP][GRP];
  logic [pal_pkg::WORD_W-1:0] grp_or [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar k = 0; k < GRP; k++) begin : g_leaf
      if (g * GRP + k < DEPTH) begin : g_used
        assign grp_in[g][k] = cell_rd[g*GRP+k];
      end else begin : g_pad
        assign grp_in[g][k] = '0;
      end
    end
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP; k++) grp_or[g] = grp_or[g] | grp_in[g][k];
    end
  end

  // --- stage 1 and output register
  logic                       s1_v_r, s1_adv;
  logic                       s1_ok_r;
  logic [pal_pkg::CNT_W-1:0]  s1_cnt_r;
  logic [pal_pkg::WORD_W-1:0] s1_grp_r [NGRP];
  logic [pal_pkg::WORD_W-1:0] s1_rd;

  logic                       out_v_r;
  logic                       out_ok_r;
  logic [pal_pkg::WORD_W-1:0] out_rd_r;
  logic [pal_pkg::CNT_W-1:0]  out_cnt_r;

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n)         s1_v_r <= 1'b0;
    else if (in_tready) s1_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ok_r  <= op_ok;
      s1_cnt_r <= cnt_nxt;
      s1_grp_r <= grp_or;
    end
  end

  always_comb begin
    s1_rd = '0;
    for (int g = 0; g < NGRP; g++) s1_rd = s1_rd | s1_grp_r[g];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      out_v_r <= 1'b0;
    else if (s1_adv) out_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_ok_r  <= s1_ok_r;
      out_rd_r  <= s1_rd;
      out_cnt_r <= s1_cnt_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_cnt_r, out_rd_r, out_ok_r};

endmodule

// ===== hdl/pal_checker.sv =====
// ---------------------------------------------------------------------------
// pal_checker : port-level checks of the positional array list
// Watches the result channel over time; bound to the top level below.
// ---------------------------------------------------------------------------
module pal_checker #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  localparam logic [7:0] DEPTH_LIM = (DEPTH > 127) ? 8'd127 : 8'(DEPTH);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == 32'd0)
    else $error("failed transaction returned a word");

  a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> {1'b0, out_tdata[39:33]} <= DEPTH_LIM)
    else $error("count beyond store depth");

endmodule

bind positional_array_list pal_checker #(.DEPTH(DEPTH)) u_pal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
